// File: rtl/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

	localparam int MAX_FRAMES = 256;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam int CNT_W   = 17;
	localparam int FRAME_W = 8;
	localparam int DIV_W   = 9;
	localparam int RND_W   = 16;
	localparam int COORD_W = 24;
	localparam int SIZE_W  = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [DIV_W-1:0] FRAME_LIMIT =
		(MAX_FRAMES < 256) ? DIV_W'(MAX_FRAMES) : DIV_W'(256);

	localparam logic [CFG_AW-1:0] REG_PLAY_MODE     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_TICK_DELAY    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_FRAME_TOTAL   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SHEET_COLUMNS = 3'd3;
	localparam logic [CFG_AW-1:0] REG_FIXED_FRAME   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_FRAME_SIZE    = 3'd5;
	localparam logic [CFG_AW-1:0] REG_SHEET_ORIGIN  = 3'd6;

	localparam logic [1:0] MODE_LOOP     = 2'd0;
	localparam logic [1:0] MODE_PINGPONG = 2'd1;
	localparam logic [1:0] MODE_RANDOM   = 2'd2;
	localparam logic [1:0] MODE_STILL    = 2'd3;

	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

endpackage

`default_nettype wire

// File: rtl/sprite_frame_sequencer.sv
`default_nettype none

// channel  | handshake                   | payload
// ---------+-----------------------------+-------------------------------
// in       | in_valid / in_ready         | func, random_value
// out      | out_valid / out_ready       | frame_index, tex_x, tex_y
// cfg      | cfg_wr_en (no wait)         | cfg_addr, cfg_wdata
//
// a tick item steps through accept, the shared bit-serial divider for column
// and row, the shift-add multiplier and the output load, in that order
// a random-mode advance first runs the divider for random_value mod frames
// a restart item gives no result
// arst_n clears state, counters and registers, but sets frame total, sheet columns and divisor to one
// a result waiting on out_ready holds the item after it in the final stage

module sprite_frame_sequencer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        func,
	input  wire logic [sfs_pkg::RND_W-1:0]   random_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [sfs_pkg::FRAME_W-1:0]      frame_index,
	output logic [sfs_pkg::COORD_W-1:0]      tex_x,
	output logic [sfs_pkg::COORD_W-1:0]      tex_y,
	input  wire logic                        cfg_wr_en,
	input  wire logic [sfs_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [sfs_pkg::CFG_DW-1:0]  cfg_wdata
);
	import sfs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RND,
		S_COL,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;

	logic [2:0]         mode_q;
	logic [15:0]        delay_q;
	logic [DIV_W-1:0]   total_q;
	logic [DIV_W-1:0]   cols_q;
	logic [FRAME_W-1:0] fixed_q;
	logic [31:0]        size_q;
	logic [31:0]        origin_q;

	logic [CNT_W-1:0]   count_q;
	logic [FRAME_W-1:0] frame_q;
	logic               back_q;

	logic [3:0]         step_q;
	logic [DIV_W-1:0]   rem_q;
	logic [RND_W-1:0]   num_q;
	logic [DIV_W-1:0]   divisor_q;

	logic [FRAME_W-1:0] mx_q;
	logic [FRAME_W-1:0] my_q;
	logic [COORD_W-1:0] mcx_q;
	logic [COORD_W-1:0] mcy_q;
	logic [COORD_W-1:0] accx_q;
	logic [COORD_W-1:0] accy_q;

	logic               out_valid_q;
	logic [FRAME_W-1:0] frame_out_q;
	logic [COORD_W-1:0] tex_x_q;
	logic [COORD_W-1:0] tex_y_q;

	logic               accept;
	logic               still;
	logic               advance;
	logic [DIV_W-1:0]   n_eff;
	logic [DIV_W-1:0]   n_m1;
	logic [DIV_W-1:0]   cols_eff;
	logic [DIV_W-1:0]   frame_ext;
	logic [FRAME_W-1:0] frame_adv;
	logic               back_adv;

	logic [DIV_W:0]     trial;
	logic               trial_ge;
	logic [DIV_W-1:0]   rem_next;
	logic [RND_W-1:0]   num_next;

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign frame_index = frame_out_q;
	assign tex_x       = tex_x_q;
	assign tex_y       = tex_y_q;

	assign still    = (mode_q[1:0] == MODE_STILL);
	assign advance  = ({1'b0, count_q} > {2'b00, delay_q}) && !still;
	assign cols_eff = (cols_q == '0) ? DIV_W'(1) : cols_q;
	assign n_m1     = n_eff - DIV_W'(1);
	assign frame_ext = {1'b0, frame_q};

	always_comb begin
		if (total_q == '0) begin
			n_eff = DIV_W'(1);
		end else if (total_q > FRAME_LIMIT) begin
			n_eff = FRAME_LIMIT;
		end else begin
			n_eff = total_q;
		end
	end

	// next frame for loop and ping-pong
	always_comb begin
		frame_adv = frame_q;
		back_adv  = back_q;
		case (mode_q[1:0])
			MODE_PINGPONG: begin
				if (!back_q && frame_ext >= n_m1) begin
					back_adv  = 1'b1;
					frame_adv = (frame_q != '0) ? frame_q - FRAME_W'(1) : '0;
				end else if (!back_q) begin
					frame_adv = frame_q + FRAME_W'(1);
				end else if (frame_q == '0) begin
					back_adv  = 1'b0;
					frame_adv = (n_eff > DIV_W'(1)) ? FRAME_W'(1) : '0;
				end else begin
					frame_adv = frame_q - FRAME_W'(1);
				end
			end
			default: begin
				frame_adv = (frame_ext >= n_m1) ? '0 : frame_q + FRAME_W'(1);
			end
		endcase
	end

	// one restoring divider step
	assign trial    = {rem_q, num_q[RND_W-1]};
	assign trial_ge = (trial >= {1'b0, divisor_q});
	assign rem_next = trial_ge ? DIV_W'(trial - {1'b0, divisor_q}) : trial[DIV_W-1:0];
	assign num_next = {num_q[RND_W-2:0], trial_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mode_q      <= '0;
			delay_q     <= '0;
			total_q     <= DIV_W'(1);
			cols_q      <= DIV_W'(1);
			fixed_q     <= '0;
			size_q      <= '0;
			origin_q    <= '0;
			count_q     <= '0;
			frame_q     <= '0;
			back_q      <= 1'b0;
			step_q      <= '0;
			rem_q       <= '0;
			num_q       <= '0;
			divisor_q   <= DIV_W'(1);
			mx_q        <= '0;
			my_q        <= '0;
			mcx_q       <= '0;
			mcy_q       <= '0;
			accx_q      <= '0;
			accy_q      <= '0;
			frame_out_q <= '0;
			tex_x_q     <= '0;
			tex_y_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_PLAY_MODE:     mode_q   <= cfg_wdata[2:0];
					REG_TICK_DELAY:    delay_q  <= cfg_wdata[15:0];
					REG_FRAME_TOTAL:   total_q  <= cfg_wdata[DIV_W-1:0];
					REG_SHEET_COLUMNS: cols_q   <= cfg_wdata[DIV_W-1:0];
					REG_FIXED_FRAME:   fixed_q  <= cfg_wdata[FRAME_W-1:0];
					REG_FRAME_SIZE:    size_q   <= cfg_wdata;
					REG_SHEET_ORIGIN:  origin_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FUNC_RESTART) begin
							frame_q <= '0;
							count_q <= '0;
						end else if (advance) begin
							count_q <= '0;
							if (mode_q[1:0] == MODE_RANDOM) begin
								rem_q     <= '0;
								num_q     <= random_value;
								divisor_q <= n_eff;
								step_q    <= 4'd15;
								state_q   <= S_RND;
							end else begin
								frame_q   <= frame_adv;
								back_q    <= back_adv;
								rem_q     <= '0;
								num_q     <= {frame_adv, 8'b0};
								divisor_q <= cols_eff;
								step_q    <= 4'd7;
								state_q   <= S_COL;
							end
						end else begin
							if (count_q != CNT_MAX) begin
								count_q <= count_q + CNT_W'(1);
							end
							rem_q     <= '0;
							divisor_q <= cols_eff;
							step_q    <= 4'd7;
							state_q   <= S_COL;
							if (still) begin
								frame_q <= fixed_q;
								num_q   <= {fixed_q, 8'b0};
							end else begin
								num_q   <= {frame_q, 8'b0};
							end
						end
					end
				end
				S_RND: begin
					if (step_q == '0) begin
						frame_q   <= rem_next[FRAME_W-1:0];
						rem_q     <= '0;
						num_q     <= {rem_next[FRAME_W-1:0], 8'b0};
						divisor_q <= cols_eff;
						step_q    <= 4'd7;
						state_q   <= S_COL;
					end else begin
						rem_q  <= rem_next;
						num_q  <= num_next;
						step_q <= step_q - 4'd1;
					end
				end
				S_COL: begin
					if (step_q == '0) begin
						mx_q    <= rem_next[FRAME_W-1:0];
						my_q    <= mode_q[2] ? num_next[FRAME_W-1:0] : '0;
						mcx_q   <= {8'b0, size_q[SIZE_W-1:0]};
						mcy_q   <= {8'b0, size_q[31:16]};
						accx_q  <= {8'b0, origin_q[SIZE_W-1:0]};
						accy_q  <= {8'b0, origin_q[31:16]};
						step_q  <= 4'd7;
						state_q <= S_MUL;
					end else begin
						rem_q  <= rem_next;
						num_q  <= num_next;
						step_q <= step_q - 4'd1;
					end
				end
				S_MUL: begin
					if (mx_q[0]) begin
						accx_q <= accx_q + mcx_q;
					end
					if (my_q[0]) begin
						accy_q <= accy_q + mcy_q;
					end
					mcx_q <= {mcx_q[COORD_W-2:0], 1'b0};
					mcy_q <= {mcy_q[COORD_W-2:0], 1'b0};
					mx_q  <= {1'b0, mx_q[FRAME_W-1:1]};
					my_q  <= {1'b0, my_q[FRAME_W-1:1]};
					if (step_q == '0) begin
						state_q <= S_OUT;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						frame_out_q <= frame_q;
						tex_x_q     <= accx_q;
						tex_y_q     <= accy_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RND || state_q == S_COL) |-> (rem_q < divisor_q))
		else $error("divider remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_RESTART) |=> (frame_q == '0 && count_q == '0
			&& state_q == S_IDLE))
		else $error("restart did not clear frame and counter");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!out_valid_q || out_ready))
			|=> (out_valid_q && state_q == S_IDLE))
		else $error("finished item not loaded into output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_TICK && !(advance && mode_q[1:0] == MODE_RANDOM))
			|=> (state_q == S_COL && step_q == 4'd7))
		else $error("tick item did not start column divide");
`endif

endmodule

`default_nettype wire
